FILE: hw/rtl/eas_pkg.sv
// ----------------------------------------------------------------------------
// eas_pkg: shared types and constants for the encoder angle/speed/position block
// sequencer states, register indexes, clamp limits and register reset values
// ----------------------------------------------------------------------------
package eas_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELEC,
		ST_SPEED,
		ST_FILT,
		ST_WB
	} eas_state_t;

	// configuration register indexes
	localparam logic [1:0] REG_ZERO_OFFSET  = 2'd0;
	localparam logic [1:0] REG_POLE_COUNT   = 2'd1;
	localparam logic [1:0] REG_SAMPLE_RATE  = 2'd2;
	localparam logic [1:0] REG_FILTER_ALPHA = 2'd3;

	// field widths fixed by the interface
	localparam int RAW_W   = 12;
	localparam int PP_W    = 7;
	localparam int RATE_W  = 14;
	localparam int ALPHA_W = 17;
	localparam int ELEC_W  = 18;
	localparam int SPD_W   = 34;
	localparam int POS_W   = 40;
	localparam int CFG_W   = 17;

	// clamp limits
	localparam logic [PP_W-1:0]    PP_MAX    = 7'd64;
	localparam logic [RATE_W-1:0]  RATE_MAX  = 14'd10000;
	localparam logic [ALPHA_W-1:0] ALPHA_MAX = 17'd65536;

	// register reset values
	localparam logic [RAW_W-1:0]   ZERO_OFFSET_RST  = 12'd0;
	localparam logic [PP_W-1:0]    POLE_COUNT_RST   = 7'd1;
	localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST  = 14'd100;
	localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 17'd6554;

	// multi-turn position limits
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

endpackage

FILE: hw/rtl/encoder_angle_speed_position.sv
// ----------------------------------------------------------------------------
// encoder_angle_speed_position: encoder angle, filtered speed and turn counter
// one absolute encoder sample in, one angle/speed/position result out
// ----------------------------------------------------------------------------
// Each sample on the s_ side is offset-corrected and wrapped to the mechanical
// angle, multiplied by the pole pairs for the electrical angle (not wrapped),
// and differenced against the previous angle with the change wrapped into plus
// or minus half a turn. The change times the sample rate, in Q8, drives a
// first-order low-pass filter new = old + (alpha*(raw*256 - old))>>>16; the
// change adds to a saturating 40-bit multi-turn position. All three products go
// through one shift-add multiplier that retires one multiplier bit per cycle and
// ends a product once no set multiplier bit is left. s_tready is high only
// while the sequencer is idle; a finished result waits in the output register,
// so the next sample can be taken before it is read. Registers are written
// through the cfg port, which is always ready; write them only while no item
// is in flight.
module encoder_angle_speed_position
	import eas_pkg::*;
#(
	parameter int ANGLE_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// sample stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // [11:0] encoder count
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [111:0]       m_tdata    // [11:0] mech_angle, [29:12] elec_pos,
	                                      // [63:30] speed_q8, [103:64] position,
	                                      // [104] position_saturated
);

	localparam int AW  = ANGLE_BITS;   // angle width
	localparam int DW  = AW + 1;       // signed angle change
	localparam int SPW = AW + 23;      // signed speed, change * rate * 256
	localparam int PW  = SPW + 18;     // product of alpha and speed error

	localparam logic signed [AW+1:0] HALF_C = (AW+2)'(2 ** (AW - 1));
	localparam logic signed [AW+1:0] FULL_C = (AW+2)'(2 ** AW);

	// configuration registers
	logic [RAW_W-1:0]   zero_offset_q;
	logic [PP_W-1:0]    pole_count_q;
	logic [RATE_W-1:0]  sample_rate_q;
	logic [ALPHA_W-1:0] filter_alpha_q;

	// sequencer and block state
	eas_state_t              state_q, state_d;
	logic [AW-1:0]           prev_angle_q;
	logic signed [SPW-1:0]   filt_q;
	logic signed [POS_W-1:0] pos_q;

	// working registers of the current item
	logic [AW-1:0]           mech_q;
	logic signed [DW-1:0]    diff_q;
	logic [ELEC_W-1:0]       elec_q;

	// shared shift-add multiplier
	logic signed [PW-1:0]    acc_q;
	logic signed [PW-1:0]    mcand_q;
	logic [ALPHA_W-1:0]      mplier_q;

	// output register
	logic                    out_valid_q;
	logic [RAW_W-1:0]        out_mech_q;
	logic [ELEC_W-1:0]       out_elec_q;
	logic [SPD_W-1:0]        out_speed_q;
	logic signed [POS_W-1:0] out_pos_q;
	logic                    out_sat_q;

	// combinational
	logic                    in_fire;
	logic                    wb_fire;
	logic                    mul_done;
	logic [AW-1:0]           raw_a;
	logic [AW-1:0]           off_a;
	logic [AW-1:0]           mech_d;
	logic signed [AW+1:0]    delta0;
	logic signed [AW+1:0]    delta_w;
	logic signed [DW-1:0]    diff_d;
	logic [PP_W-1:0]         pp_clamp;
	logic [RATE_W-1:0]       rate_clamp;
	logic [ALPHA_W-1:0]      alpha_clamp;
	logic signed [PW-1:0]    mul_add;
	logic signed [SPW-1:0]   target_w;
	logic signed [SPW:0]     err_w;
	logic signed [SPW-1:0]   filt_new;
	logic signed [POS_W:0]   pos_sum;
	logic                    pos_ovf;
	logic signed [POS_W-1:0] pos_new;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign mul_done  = (mplier_q == '0);

	// ---------------- angle and change ----------------
	assign raw_a  = AW'({20'd0, s_tdata[RAW_W-1:0]});
	assign off_a  = AW'({20'd0, zero_offset_q});
	assign mech_d = raw_a - off_a;   // wraps modulo one turn
	assign delta0 = signed'({2'b00, mech_d}) - signed'({2'b00, prev_angle_q});

	// wrap the change into plus or minus half a turn, half a turn itself kept
	always_comb begin
		priority if (delta0 > HALF_C) begin
			delta_w = delta0 - FULL_C;
		end else if (delta0 < -HALF_C) begin
			delta_w = delta0 + FULL_C;
		end else begin
			delta_w = delta0;
		end
	end
	assign diff_d = delta_w[DW-1:0];

	// ---------------- register clamps ----------------
	assign pp_clamp    = (pole_count_q > PP_MAX) ? PP_MAX : pole_count_q;
	assign rate_clamp  = (sample_rate_q > RATE_MAX) ? RATE_MAX : sample_rate_q;
	assign alpha_clamp = (filter_alpha_q > ALPHA_MAX) ? ALPHA_MAX : filter_alpha_q;

	// ---------------- multiplier step and stage glue ----------------
	assign mul_add  = mplier_q[0] ? mcand_q : '0;
	// raw speed in q8: change * rate shifted up by eight
	assign target_w = signed'(SPW'(acc_q << 8));
	assign err_w    = signed'({target_w[SPW-1], target_w} - {filt_q[SPW-1], filt_q});
	// arithmetic shift gives the floor of the product over 65536
	assign filt_new = filt_q + signed'(SPW'(acc_q >>> 16));

	// saturating multi-turn position
	assign pos_sum = signed'({pos_q[POS_W-1], pos_q} + {{(POS_W+1-DW){diff_q[DW-1]}}, diff_q});
	assign pos_ovf = (pos_sum[POS_W] != pos_sum[POS_W-1]);
	assign pos_new = pos_ovf ? (pos_sum[POS_W] ? POS_MIN : POS_MAX) : pos_sum[POS_W-1:0];

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_ELEC;
			ST_ELEC:  if (mul_done) state_d = ST_SPEED;
			ST_SPEED: if (mul_done) state_d = ST_FILT;
			ST_FILT:  if (mul_done) state_d = ST_WB;
			ST_WB:    if (wb_fire) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		wb_fire  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			// result goes out when the output register is free or being read
			ST_WB:   wb_fire = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// ---------------- control and state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			zero_offset_q  <= ZERO_OFFSET_RST;
			pole_count_q   <= POLE_COUNT_RST;
			sample_rate_q  <= SAMPLE_RATE_RST;
			filter_alpha_q <= FILTER_ALPHA_RST;
			prev_angle_q   <= '0;
			filt_q         <= '0;
			pos_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ZERO_OFFSET:  zero_offset_q  <= cfg_data[RAW_W-1:0];
					REG_POLE_COUNT:   pole_count_q   <= cfg_data[PP_W-1:0];
					REG_SAMPLE_RATE:  sample_rate_q  <= cfg_data[RATE_W-1:0];
					REG_FILTER_ALPHA: filter_alpha_q <= cfg_data[ALPHA_W-1:0];
					default: ;
				endcase
			end
			if (wb_fire) begin
				prev_angle_q <= mech_q;
				filt_q       <= filt_new;
				pos_q        <= pos_new;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					mech_q   <= mech_d;
					diff_q   <= diff_d;
					acc_q    <= '0;
					mcand_q  <= signed'({{(PW-AW){1'b0}}, mech_d});
					mplier_q <= {{(ALPHA_W-PP_W){1'b0}}, pp_clamp};
				end
			end
			ST_ELEC: begin
				if (mul_done) begin
					elec_q   <= acc_q[ELEC_W-1:0];
					acc_q    <= '0;
					mcand_q  <= signed'({{(PW-DW){diff_q[DW-1]}}, diff_q});
					mplier_q <= {{(ALPHA_W-RATE_W){1'b0}}, rate_clamp};
				end else begin
					acc_q    <= acc_q + mul_add;
					mcand_q  <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_SPEED: begin
				if (mul_done) begin
					acc_q    <= '0;
					mcand_q  <= signed'({{(PW-SPW-1){err_w[SPW]}}, err_w});
					mplier_q <= alpha_clamp;
				end else begin
					acc_q    <= acc_q + mul_add;
					mcand_q  <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_FILT: begin
				// product stays in the accumulator for write-back
				if (!mul_done) begin
					acc_q    <= acc_q + mul_add;
					mcand_q  <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			default: ;
		endcase

		if (wb_fire) begin
			out_mech_q  <= RAW_W'({{(32-AW){1'b0}}, mech_q});
			out_elec_q  <= elec_q;
			out_speed_q <= filt_new[SPD_W-1:0];
			out_pos_q   <= pos_new;
			out_sat_q   <= pos_ovf;
		end
	end

	// ---------------- result port ----------------
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_sat_q, out_pos_q, out_speed_q, out_elec_q, out_mech_q};

	// ---------------- assertions ----------------
	// an accepted sample always starts the electrical-angle product
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_ELEC))
		else $error("accepted sample did not start the multiplier");

	// pole pairs are clamped, so the electrical-angle multiplier never exceeds seven bits
	a_elec_mplier: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELEC) |-> (mplier_q[ALPHA_W-1:PP_W] == '0))
		else $error("pole-pair multiplier wider than its clamp");

	// sample rate multiplier fits fourteen bits
	a_speed_mplier: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPEED) |-> (mplier_q[ALPHA_W-1:RATE_W] == '0))
		else $error("sample-rate multiplier wider than its clamp");

	// a new result only appears out of write-back
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_WB))
		else $error("result raised outside write-back");

	// a saturated sample reports a position at one of its limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_sat_q) |-> (out_pos_q == POS_MAX || out_pos_q == POS_MIN))
		else $error("saturation flag without position at a limit");

endmodule
